// ===== sv/rat_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational ALU package
// Operation codes, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rat_pkg;

	localparam int RES_W = 33;
	localparam int DIV_W = 32;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_N,
		ST_MUL_X,
		ST_MUL_D,
		ST_CHECK,
		ST_EUC_GO,
		ST_EUC_WAIT,
		ST_QN_GO,
		ST_QN_WAIT,
		ST_QD_GO,
		ST_QD_WAIT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_N,
		OP_MUL_X,
		OP_MUL_D,
		OP_SETUP,
		OP_EUC_GO,
		OP_EUC_STEP,
		OP_QN_GO,
		OP_QN_TAKE,
		OP_QD_GO,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
	} rat_cmd_t;

	typedef struct packed {
		logic zero_part;
		logic div_done;
		logic rem_zero;
	} rat_status_t;

endpackage

// ===== sv/rat_div.sv =====
// ----------------------------------------------------------------------------
// Rational ALU divider
// Unsigned restoring divider, one quotient bit per cycle. The divisor must
// be non-zero; quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module rat_div #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] dvsr,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	assign trial = {r_q, q_q[W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= dvsr;
		end else if (run_q) begin
			r_q <= ge ? diff[W-1:0] : trial[W-1:0];
			q_q <= {q_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

// ===== sv/rat_dp.sv =====
// ----------------------------------------------------------------------------
// Rational ALU datapath
// Operand registers, the shared multiplier, the Euclid registers, the
// divider and the result registers, all driven by controller commands.
// ----------------------------------------------------------------------------
module rat_dp #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rat_pkg::rat_cmd_t                cmd,
	output rat_pkg::rat_status_t             status,
	input  logic [1:0]                       func,
	input  logic signed [OPERAND_BITS-1:0]   a_num,
	input  logic signed [OPERAND_BITS-1:0]   a_den,
	input  logic signed [OPERAND_BITS-1:0]   b_num,
	input  logic signed [OPERAND_BITS-1:0]   b_den,
	output logic                             done,
	output logic signed [rat_pkg::RES_W-1:0] res_num,
	output logic signed [rat_pkg::RES_W-1:0] res_den,
	output logic [rat_pkg::DIV_W-1:0]        divisor
);

	import rat_pkg::*;

	localparam int PROD_W = 2 * OPERAND_BITS;
	localparam int RAW_W  = PROD_W + 1;

	func_t                          func_q;
	logic signed [OPERAND_BITS-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [OPERAND_BITS-1:0] mul_x, mul_y;
	logic signed [PROD_W-1:0]       product;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [RAW_W-1:0]        n_q, d_q;
	logic signed [RAW_W-1:0]        prod_ext;
	logic [RAW_W-1:0]               mag_n, mag_d;
	logic [RAW_W-1:0]               big_q, small_q, g_q, qn_q;
	logic [RAW_W-1:0]               div_dvd, div_dvs, div_quo, div_rem;
	logic                           div_done;
	logic signed [RAW_W-1:0]        num_out, den_out;
	logic signed [RES_W-1:0]        res_num_q, res_den_q;
	logic [DIV_W-1:0]               divisor_q;
	logic                           done_q;

	// One multiplier serves all three cross products.
	always_comb begin
		mul_x = an_q;
		mul_y = bd_q;
		case (cmd.op)
			OP_MUL_N: begin
				mul_x = an_q;
				mul_y = (func_q == FUNC_MUL) ? bn_q : bd_q;
			end
			OP_MUL_X: begin
				mul_x = ad_q;
				mul_y = bn_q;
			end
			OP_MUL_D: begin
				mul_x = ad_q;
				mul_y = (func_q == FUNC_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_x = an_q;
				mul_y = bd_q;
			end
		endcase
	end

	assign product  = mul_x * mul_y;
	assign prod_ext = {prod_q[PROD_W-1], prod_q};

	assign mag_n = n_q[RAW_W-1] ? unsigned'(-n_q) : unsigned'(n_q);
	assign mag_d = d_q[RAW_W-1] ? unsigned'(-d_q) : unsigned'(d_q);

	always_comb begin
		case (cmd.op)
			OP_QN_GO: begin
				div_dvd = mag_n;
				div_dvs = g_q;
			end
			OP_QD_GO: begin
				div_dvd = mag_d;
				div_dvs = g_q;
			end
			default: begin
				div_dvd = big_q;
				div_dvs = small_q;
			end
		endcase
	end

	rat_div #(
		.W (RAW_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.dvsr      (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Each part takes back the sign it had when it was formed.
	assign num_out = n_q[RAW_W-1] ? -signed'(qn_q) : signed'(qn_q);
	assign den_out = d_q[RAW_W-1] ? -signed'(div_quo) : signed'(div_quo);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q <= func_t'(func);
				an_q   <= a_num;
				ad_q   <= a_den;
				bn_q   <= b_num;
				bd_q   <= b_den;
			end
			OP_MUL_N: begin
				n_q <= {product[PROD_W-1], product};
			end
			OP_MUL_X: begin
				prod_q <= product;
			end
			OP_MUL_D: begin
				d_q <= {product[PROD_W-1], product};
				if (func_q == FUNC_ADD) begin
					n_q <= n_q + prod_ext;
				end else if (func_q == FUNC_SUB) begin
					n_q <= n_q - prod_ext;
				end
			end
			OP_SETUP: begin
				if (status.zero_part) begin
					res_num_q <= RES_W'(n_q);
					res_den_q <= RES_W'(d_q);
					divisor_q <= DIV_W'(1);
				end else begin
					big_q   <= (mag_n > mag_d) ? mag_n : mag_d;
					small_q <= (mag_n > mag_d) ? mag_d : mag_n;
				end
			end
			OP_EUC_STEP: begin
				if (status.rem_zero) begin
					g_q <= small_q;
				end else begin
					big_q   <= small_q;
					small_q <= div_rem;
				end
			end
			OP_QN_TAKE: begin
				qn_q <= div_quo;
			end
			OP_FINISH: begin
				res_num_q <= RES_W'(num_out);
				res_den_q <= RES_W'(den_out);
				divisor_q <= DIV_W'(g_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_FINISH) ||
				((cmd.op == OP_SETUP) && status.zero_part);
		end
	end

	assign status.zero_part = (n_q == '0) || (d_q == '0);
	assign status.div_done  = div_done;
	assign status.rem_zero  = (div_rem == '0);

	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign divisor = divisor_q;

endmodule

// ===== sv/rat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rational ALU controller
// Sequences the cross products, the Euclid remainder loop and the two final
// divisions through commands to the datapath.
// ----------------------------------------------------------------------------
module rat_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rat_pkg::rat_status_t status,
	output rat_pkg::rat_cmd_t    cmd,
	output logic                 busy
);

	import rat_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_MUL_N;
			ST_MUL_N:    state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_CHECK;
			ST_CHECK:    state_d = status.zero_part ? ST_IDLE : ST_EUC_GO;
			ST_EUC_GO:   state_d = ST_EUC_WAIT;
			ST_EUC_WAIT: begin
				if (status.div_done) begin
					state_d = status.rem_zero ? ST_QN_GO : ST_EUC_GO;
				end
			end
			ST_QN_GO:    state_d = ST_QN_WAIT;
			ST_QN_WAIT:  if (status.div_done) state_d = ST_QD_GO;
			ST_QD_GO:    state_d = ST_QD_WAIT;
			ST_QD_WAIT:  if (status.div_done) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op        = OP_NOP;
		cmd.div_start = 1'b0;
		busy          = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     if (start) cmd.op = OP_LOAD;
			ST_MUL_N:    cmd.op = OP_MUL_N;
			ST_MUL_X:    cmd.op = OP_MUL_X;
			ST_MUL_D:    cmd.op = OP_MUL_D;
			ST_CHECK:    cmd.op = OP_SETUP;
			ST_EUC_GO: begin
				cmd.op        = OP_EUC_GO;
				cmd.div_start = 1'b1;
			end
			ST_EUC_WAIT: if (status.div_done) cmd.op = OP_EUC_STEP;
			ST_QN_GO: begin
				cmd.op        = OP_QN_GO;
				cmd.div_start = 1'b1;
			end
			ST_QN_WAIT:  if (status.div_done) cmd.op = OP_QN_TAKE;
			ST_QD_GO: begin
				cmd.op        = OP_QD_GO;
				cmd.div_start = 1'b1;
			end
			ST_QD_WAIT:  if (status.div_done) cmd.op = OP_FINISH;
			default:     cmd.op = OP_NOP;
		endcase
	end

endmodule

// ===== sv/rational_alu_with_gcd_reduce.sv =====
// ----------------------------------------------------------------------------
// Rational ALU with GCD reduction
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the greatest common divisor of its parts.
//
//   channel   handshake          fields
//   request   start / busy       func, a_num, a_den, b_num, b_den
//   result    done (strobe)      res_num, res_den, divisor
//
// A request is taken when start is high and busy is low; busy stays high
// until the result strobe. The divider is W = 2*OPERAND_BITS+1 (33 by default)
// bits wide. Every division runs on the one shared divider: the Euclid
// steps, then the two final quotients; none is run when a part is zero.
// The result is shown for one cycle only and cannot be stalled.
// Reset is asynchronous and leaves the block idle.
// ----------------------------------------------------------------------------
module rational_alu_with_gcd_reduce #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic signed [OPERAND_BITS-1:0]   a_num,
	input  logic signed [OPERAND_BITS-1:0]   a_den,
	input  logic signed [OPERAND_BITS-1:0]   b_num,
	input  logic signed [OPERAND_BITS-1:0]   b_den,
	output logic                             done,
	output logic signed [rat_pkg::RES_W-1:0] res_num,
	output logic signed [rat_pkg::RES_W-1:0] res_den,
	output logic [rat_pkg::DIV_W-1:0]        divisor
);

	import rat_pkg::*;

	rat_cmd_t    cmd;
	rat_status_t status;

	rat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	rat_dp #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.func    (func),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.done    (done),
		.res_num (res_num),
		.res_den (res_den),
		.divisor (divisor)
	);

	// The result strobe only comes once the controller has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	a_divisor_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (divisor != '0))
		else $error("zero divisor reported");

endmodule
